FILE: sv/ghe_pkg.sv
// Shared types, constants and helpers for the gradient weighted histogram equalizer.
// No dependencies; used by ghe_front, ghe_back and the top level.
package ghe_pkg;

    // Operation codes of an input request
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_MAP   = 2'd2;

    // Result kinds
    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_MAP   = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BLEND  = 2'd2;

    localparam int BINS       = 256;
    localparam int MAX_HEIGHT = 1024;
    localparam int HIST_W     = 32;
    localparam int SUM_W      = 40;
    localparam int NUM_W      = 48;
    localparam int SQ_W       = 22;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] hue;
        logic [7:0] intensity;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] mapped_intensity;
    } t_out_item;

    // Request class after decode in the front end
    typedef enum logic [1:0] {
        CLS_LOAD,
        CLS_BUILD,
        CLS_MAP
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] hue;
        logic [7:0] intensity;
    } t_job;

    // Queue head, front to back
    typedef struct packed {
        logic valid;
        t_job job;
    } t_fe_req;

    // Back end status, back to front
    typedef struct packed {
        logic clearing;
        logic pop;
    } t_be_stat;

    // One line buffer column: previous row and the row before it
    typedef struct packed {
        logic [7:0] i1;
        logic [8:0] h1;
        logic [7:0] i2;
        logic [8:0] h2;
    } t_line;

    // Circular hue distance, wraps at 180 degrees
    function automatic logic [7:0] wrap_diff(input logic [8:0] a, input logic [8:0] b);
        logic [8:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return (d <= 9'd180) ? d[7:0] : 8'(9'd360 - d);
    endfunction

endpackage

FILE: sv/ghe_front.sv
// Front end: takes requests, decodes the operation and queues them for the back end.
// Depends on ghe_pkg.
module ghe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ghe_pkg::t_in_item i_in_data,
    output ghe_pkg::t_fe_req  o_req,
    input  ghe_pkg::t_be_stat i_stat
);

    ghe_pkg::t_job r_q [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    ghe_pkg::t_job job;
    logic          keep;
    logic          push;

    // Decode: unknown operations are taken and dropped
    always_comb begin
        job.hue       = i_in_data.hue;
        job.intensity = i_in_data.intensity;
        job.cls       = ghe_pkg::CLS_LOAD;
        keep          = 1'b1;
        unique case (i_in_data.operation)
            ghe_pkg::OP_LOAD:  job.cls = ghe_pkg::CLS_LOAD;
            ghe_pkg::OP_BUILD: job.cls = ghe_pkg::CLS_BUILD;
            ghe_pkg::OP_MAP:   job.cls = ghe_pkg::CLS_MAP;
            default:           keep    = 1'b0;
        endcase
    end

    assign o_in_ready  = (r_cnt != 2'd2) && !i_stat.clearing;
    assign push        = i_in_valid && o_in_ready && keep;
    assign o_req.valid = (r_cnt != 2'd0);
    assign o_req.job   = r_q[r_rd];

    // Two entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wr] <= job;
                r_wr      <= ~r_wr;
            end
            if (i_stat.pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_stat.pop);
        end
    end

endmodule

FILE: sv/ghe_back.sv
// Back end: line buffers, Sobel and hue gradients, iterative square root,
// gradient histograms, mapping build with bit-serial dividers, output register.
// Depends on ghe_pkg.
module ghe_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ghe_pkg::t_fe_req              i_req,
    output ghe_pkg::t_be_stat             o_stat,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_width,
    input  logic [10:0]                   i_height,
    input  logic [8:0]                    i_blend,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ghe_pkg::t_out_item            o_out_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LD_RD, S_LD_GRAD, S_SQRT, S_LD_WR,
        S_B_SRD, S_B_SACC, S_B_RD, S_B_ACC, S_B_DIV, S_B_MIX, S_B_FIN,
        S_MAP_RD, S_EMIT
    } t_state;

    t_state r_state;
    ghe_pkg::t_job r_job;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_col;
    logic [9:0]    r_row;
    logic [7:0]    r_win_i [3][3];
    logic [8:0]    r_win_h [3][3];
    logic [16:0]   r_hx;
    logic [8:0]    r_q0;
    logic [7:0]    r_bin;
    logic [ghe_pkg::SQ_W-1:0] r_rem_i, r_rem_h, r_res_i, r_res_h, r_bit;
    logic [7:0]    r_k;
    logic [ghe_pkg::SUM_W-1:0] r_tot_i, r_tot_h, r_ci, r_ch;
    logic [ghe_pkg::NUM_W-1:0] r_num_i, r_num_h;
    logic [7:0]    r_qi, r_qh;
    logic [2:0]    r_j;
    logic [ghe_pkg::BINS-1:0] r_hvalid;
    logic [ghe_pkg::BINS-1:0] r_mvalid;
    ghe_pkg::t_out_item r_res;
    logic          r_out_valid;
    ghe_pkg::t_out_item r_out_data;

    // Memories and their read registers
    ghe_pkg::t_line   m_line [MAX_WIDTH];
    logic [63:0]      m_hist [ghe_pkg::BINS];
    logic [7:0]       m_map  [ghe_pkg::BINS];
    ghe_pkg::t_line   r_line_q;
    logic [63:0]      r_hq;
    logic             r_hv;
    logic [7:0]       r_mq;
    logic             r_mv;

    logic           pop;
    logic           line_we;
    logic [AW-1:0]  line_addr;
    ghe_pkg::t_line line_wd;
    logic           hist_re, hist_we;
    logic [7:0]     hist_raddr;
    logic [63:0]    hist_wd;
    logic           map_re, map_we;
    logic [7:0]     map_addr;
    logic [7:0]     map_wd;
    logic           emit;

    logic [31:0]    bin_i, bin_h;
    logic [32:0]    add_i, add_h;
    logic [8:0]     hs;
    logic [16:0]    hs_rem;
    logic signed [11:0] gx, gy;
    logic [9:0]     hx, hy;
    logic [ghe_pkg::SUM_W-1:0] ci_n, ch_n;
    logic [ghe_pkg::NUM_W-1:0] d_i, d_h;
    logic [7:0]     vi, vh;
    logic [17:0]    mix;
    logic [16:0]    x_n;
    logic [31:0]    q0_prod;
    logic [CW-1:0]  col_inc;

    assign pop       = (r_state == S_IDLE) && i_req.valid;
    assign emit      = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign o_stat.pop      = pop;
    assign o_stat.clearing = (r_state == S_CLR);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Bin values, zero where the bin was cleared
    assign bin_i = r_hv ? r_hq[63:32] : 32'd0;
    assign bin_h = r_hv ? r_hq[31:0]  : 32'd0;
    assign add_i = {1'b0, bin_i} + 33'(r_res_i);
    assign add_h = {1'b0, bin_h} + 33'(r_res_h);

    // Hue scaling: estimate by reciprocal, one correction step
    assign x_n     = 17'(i_req.job.hue) * 17'd360;
    assign q0_prod = 32'(x_n) * 32'd16448;
    assign hs_rem  = r_hx - ({r_q0, 8'd0} - 17'(r_q0));
    assign hs      = (hs_rem >= 17'd255) ? r_q0 + 9'd1 : r_q0;

    // Sobel on intensity, weighted circular differences on hue
    assign gx = (12'(r_win_i[2][2]) + 12'({r_win_i[2][1], 1'b0}) + 12'(r_win_i[2][0]))
              - (12'(r_win_i[0][2]) + 12'({r_win_i[0][1], 1'b0}) + 12'(r_win_i[0][0]));
    assign gy = (12'(r_win_i[2][2]) + 12'({r_win_i[1][2], 1'b0}) + 12'(r_win_i[0][2]))
              - (12'(r_win_i[2][0]) + 12'({r_win_i[1][0], 1'b0}) + 12'(r_win_i[0][0]));
    assign hx = 10'(ghe_pkg::wrap_diff(r_win_h[2][2], r_win_h[0][2]))
              + {1'b0, ghe_pkg::wrap_diff(r_win_h[2][1], r_win_h[0][1]), 1'b0}
              + 10'(ghe_pkg::wrap_diff(r_win_h[2][0], r_win_h[0][0]));
    assign hy = 10'(ghe_pkg::wrap_diff(r_win_h[2][2], r_win_h[2][0]))
              + {1'b0, ghe_pkg::wrap_diff(r_win_h[1][2], r_win_h[1][0]), 1'b0}
              + 10'(ghe_pkg::wrap_diff(r_win_h[0][2], r_win_h[0][0]));

    // Build datapath
    assign ci_n = r_ci + ghe_pkg::SUM_W'(bin_i);
    assign ch_n = r_ch + ghe_pkg::SUM_W'(bin_h);
    assign d_i  = ghe_pkg::NUM_W'(r_tot_i) << r_j;
    assign d_h  = ghe_pkg::NUM_W'(r_tot_h) << r_j;
    assign vi   = (r_tot_i == '0) ? 8'd0 : r_qi;
    assign vh   = (r_tot_h == '0) ? 8'd0 : r_qh;
    assign mix  = 18'(i_blend) * 18'(vi) + 18'(9'(9'd256 - i_blend)) * 18'(vh) + 18'd128;

    assign col_inc = CW'(r_col) + CW'(1);

    // Memory port control
    always_comb begin
        line_we    = 1'b0;
        line_addr  = r_col;
        line_wd    = '0;
        hist_re    = 1'b0;
        hist_we    = 1'b0;
        hist_raddr = r_k;
        hist_wd    = {(add_i[32] ? 32'hFFFF_FFFF : add_i[31:0]),
                      (add_h[32] ? 32'hFFFF_FFFF : add_h[31:0])};
        map_re     = 1'b0;
        map_we     = 1'b0;
        map_addr   = r_k;
        map_wd     = (mix[17:16] != 2'd0) ? 8'hFF : mix[15:8];
        case (r_state)
            S_CLR: begin
                line_we   = 1'b1;
                line_addr = r_clr;
            end
            S_IDLE: begin
                map_re   = pop && (i_req.job.cls == ghe_pkg::CLS_MAP);
                map_addr = i_req.job.intensity;
            end
            S_LD_RD: begin
                line_we = 1'b1;
                line_wd = '{i1: r_job.intensity, h1: hs, i2: r_line_q.i1, h2: r_line_q.h1};
            end
            S_LD_GRAD: begin
                hist_re    = 1'b1;
                hist_raddr = r_win_i[1][1];
            end
            S_LD_WR: hist_we = 1'b1;
            S_B_SRD, S_B_RD: hist_re = 1'b1;
            S_B_ACC: begin
                map_we = (r_k == 8'd0);
                map_wd = 8'd0;
            end
            S_B_MIX: map_we = 1'b1;
            default: ;
        endcase
    end

    // Line buffer memory
    always_ff @(posedge i_clk) begin
        if (line_we) begin
            m_line[line_addr] <= line_wd;
        end
        r_line_q <= m_line[r_col];
    end

    // Histogram memory, intensity bins in the upper half
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            m_hist[r_bin] <= hist_wd;
        end
        if (hist_re) begin
            r_hq <= m_hist[hist_raddr];
        end
    end

    // Mapping table memory
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            m_map[map_addr] <= map_wd;
        end
        if (map_re) begin
            r_mq <= m_map[map_addr];
        end
    end

    // Sequencer and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_hvalid    <= '0;
            r_mvalid    <= '0;
            r_out_valid <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    r_win_i[a][b] <= '0;
                    r_win_h[a][b] <= '0;
                end
            end
        end else begin
            if (hist_re) begin
                r_hv <= r_hvalid[hist_raddr];
            end
            if (map_re) begin
                r_mv <= r_mvalid[map_addr];
            end
            if (map_we) begin
                r_mvalid[map_addr] <= 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MAX_WIDTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (pop) begin
                        r_job <= i_req.job;
                        r_hx  <= x_n;
                        r_q0  <= q0_prod[30:22];
                        r_k   <= 8'd0;
                        unique case (i_req.job.cls)
                            ghe_pkg::CLS_LOAD:  r_state <= S_LD_RD;
                            ghe_pkg::CLS_BUILD: begin
                                r_tot_i <= '0;
                                r_tot_h <= '0;
                                r_state <= S_B_SRD;
                            end
                            ghe_pkg::CLS_MAP:   r_state <= S_MAP_RD;
                            default:            r_state <= S_IDLE;
                        endcase
                    end
                end
                S_LD_RD: begin
                    // Slide the window and bring in the new column
                    for (int a = 0; a < 3; a++) begin
                        r_win_i[a][0] <= r_win_i[a][1];
                        r_win_i[a][1] <= r_win_i[a][2];
                        r_win_h[a][0] <= r_win_h[a][1];
                        r_win_h[a][1] <= r_win_h[a][2];
                    end
                    r_win_i[0][2] <= r_line_q.i2;
                    r_win_i[1][2] <= r_line_q.i1;
                    r_win_i[2][2] <= r_job.intensity;
                    r_win_h[0][2] <= r_line_q.h2;
                    r_win_h[1][2] <= r_line_q.h1;
                    r_win_h[2][2] <= hs;
                    if (col_inc >= i_width) begin
                        r_col <= '0;
                        r_row <= (11'(r_row) + 11'd1 >= i_height) ? 10'd0 : r_row + 10'd1;
                    end else begin
                        r_col <= r_col + AW'(1);
                    end
                    r_state <= (r_row >= 10'd2 && CW'(r_col) >= CW'(2)) ? S_LD_GRAD : S_IDLE;
                end
                S_LD_GRAD: begin
                    r_bin   <= r_win_i[1][1];
                    r_rem_i <= ghe_pkg::SQ_W'(24'(gx * gx) + 24'(gy * gy));
                    r_rem_h <= ghe_pkg::SQ_W'(20'(hx) * 20'(hx) + 20'(hy) * 20'(hy));
                    r_res_i <= '0;
                    r_res_h <= '0;
                    r_bit   <= ghe_pkg::SQ_W'(1) << 20;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    // One digit pair per cycle for both roots
                    if (r_rem_i >= r_res_i + r_bit) begin
                        r_rem_i <= r_rem_i - (r_res_i + r_bit);
                        r_res_i <= (r_res_i >> 1) + r_bit;
                    end else begin
                        r_res_i <= r_res_i >> 1;
                    end
                    if (r_rem_h >= r_res_h + r_bit) begin
                        r_rem_h <= r_rem_h - (r_res_h + r_bit);
                        r_res_h <= (r_res_h >> 1) + r_bit;
                    end else begin
                        r_res_h <= r_res_h >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= S_LD_WR;
                    end
                end
                S_LD_WR: begin
                    r_hvalid[r_bin] <= 1'b1;
                    r_state         <= S_IDLE;
                end
                S_B_SRD: r_state <= S_B_SACC;
                S_B_SACC: begin
                    r_tot_i <= r_tot_i + ghe_pkg::SUM_W'(bin_i);
                    r_tot_h <= r_tot_h + ghe_pkg::SUM_W'(bin_h);
                    r_k     <= r_k + 8'd1;
                    if (r_k == 8'd255) begin
                        r_ci    <= '0;
                        r_ch    <= '0;
                        r_state <= S_B_RD;
                    end else begin
                        r_state <= S_B_SRD;
                    end
                end
                S_B_RD: r_state <= S_B_ACC;
                S_B_ACC: begin
                    r_ci    <= ci_n;
                    r_ch    <= ch_n;
                    r_num_i <= (ghe_pkg::NUM_W'(ci_n) << 8) - ghe_pkg::NUM_W'(ci_n);
                    r_num_h <= (ghe_pkg::NUM_W'(ch_n) << 8) - ghe_pkg::NUM_W'(ch_n);
                    r_qi    <= '0;
                    r_qh    <= '0;
                    r_j     <= 3'd7;
                    if (r_k == 8'd0) begin
                        r_k     <= 8'd1;
                        r_state <= S_B_RD;
                    end else begin
                        r_state <= S_B_DIV;
                    end
                end
                S_B_DIV: begin
                    // Restoring division, one quotient bit per cycle
                    if (r_num_i >= d_i) begin
                        r_num_i     <= r_num_i - d_i;
                        r_qi[r_j]   <= 1'b1;
                    end
                    if (r_num_h >= d_h) begin
                        r_num_h     <= r_num_h - d_h;
                        r_qh[r_j]   <= 1'b1;
                    end
                    r_j <= r_j - 3'd1;
                    if (r_j == 3'd0) begin
                        r_state <= S_B_MIX;
                    end
                end
                S_B_MIX: begin
                    r_k     <= r_k + 8'd1;
                    r_state <= (r_k == 8'd255) ? S_B_FIN : S_B_RD;
                end
                S_B_FIN: begin
                    r_hvalid <= '0;
                    r_col    <= '0;
                    r_row    <= '0;
                    r_res    <= '{kind: ghe_pkg::KIND_BUILD, mapped_intensity: 8'd0};
                    r_state  <= S_EMIT;
                end
                S_MAP_RD: begin
                    r_res   <= '{kind: ghe_pkg::KIND_MAP, mapped_intensity: r_mv ? r_mq : 8'd0};
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_col) < CW'(MAX_WIDTH))) else $error("column counter out of range");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid) else $error("result lost at output register");
    a_fin_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B_FIN) |=> (r_hvalid == '0)) else $error("bins not cleared");
    a_no_pop_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.clearing |-> !o_stat.pop) else $error("request taken while clearing");
`endif

endmodule

FILE: sv/gradient_weighted_histogram_equalizer.sv
// Top level of the gradient weighted histogram equalizer: configuration registers,
// front end queue and back end engine. Depends on ghe_pkg, ghe_front, ghe_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes requests: load a pixel
//   in raster order, build the mapping, or map a pixel. Output channel
//   (o_out_valid / i_out_ready / o_out_data) returns one result per build or map
//   request; loads return nothing. The user must write configuration (i_cfg_we,
//   i_cfg_index, i_cfg_data) only while the block is idle; the block itself
//   does not enforce this. Requests are handled one at a time by the back end
//   sequencer; a two entry queue lets the input side keep taking requests while
//   the back end works. A build makes two passes over the 256 histogram bins,
//   with bit-serial dividers per bin; interior loads also run the iterative
//   square root. After reset the line buffers are cleared, one column per
//   cycle, over all MAX_WIDTH columns, during which o_in_ready stays low.
//   When the receiver stalls, the result waits in the output register, the back
//   end holds, and the queue fills before o_in_ready drops.
module gradient_weighted_histogram_equalizer #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ghe_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ghe_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [10:0]        i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH + 1);

    logic [10:0] r_width;
    logic [10:0] r_height;
    logic [8:0]  r_blend;

    logic [CW-1:0] width_c;
    logic [10:0]   height_c;
    logic [8:0]    blend_c;
    logic [12:0]   width_x;

    ghe_pkg::t_fe_req  req;
    ghe_pkg::t_be_stat stat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd640;
            r_height <= 11'd480;
            r_blend  <= 9'd128;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ghe_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                ghe_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                ghe_pkg::REG_BLEND:  r_blend  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Clamp sizes and weight to their legal ranges
    assign width_x  = 13'(r_width);
    assign width_c  = (width_x < 13'd3) ? CW'(3) :
                      (width_x > 13'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_x);
    assign height_c = (r_height < 11'd3) ? 11'd3 :
                      (r_height > 11'(ghe_pkg::MAX_HEIGHT)) ? 11'(ghe_pkg::MAX_HEIGHT) : r_height;
    assign blend_c  = (r_blend > 9'd256) ? 9'd256 : r_blend;

    ghe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_req      (req),
        .i_stat     (stat)
    );

    ghe_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_stat      (stat),
        .i_width     (width_c),
        .i_height    (height_c),
        .i_blend     (blend_c),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: dv/gradient_weighted_histogram_equalizer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for gradient_weighted_histogram_equalizer: random images,
// builds and map requests are checked against an in-bench predictor of the histograms.
// Depends on ghe_pkg and the gradient_weighted_histogram_equalizer RTL.
module gradient_weighted_histogram_equalizer_tb;
    import ghe_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         MAXW      = 1024;

    // Predictor of the equalizer plus the store of expected results
    class equalizer_scoreboard;
        logic [7:0]  line_i [2*MAXW];
        logic [8:0]  line_h [2*MAXW];
        logic [7:0]  win_i [3][3];
        logic [8:0]  win_h [3][3];
        int unsigned col, row;
        logic [31:0] grad_bins [BINS];
        logic [31:0] hue_bins [BINS];
        logic [7:0]  eq_table [BINS];
        int unsigned cfg_width, cfg_height, cfg_blend;
        t_out_item   expected_results[$];
        int          errors;
        int          results_seen;

        function new();
            foreach (line_i[k]) begin
                line_i[k] = '0;
                line_h[k] = '0;
            end
            foreach (win_i[a, b]) begin
                win_i[a][b] = '0;
                win_h[a][b] = '0;
            end
            foreach (grad_bins[k]) begin
                grad_bins[k] = '0;
                hue_bins[k] = '0;
                eq_table[k] = '0;
            end
            col = 0;
            row = 0;
            cfg_width = 640;
            cfg_height = 480;
            cfg_blend = 128;
            errors = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [10:0] val);
            case (idx)
                REG_WIDTH:  cfg_width = val;
                REG_HEIGHT: cfg_height = val;
                REG_BLEND:  cfg_blend = val[8:0];
                default: ;
            endcase
        endfunction

        function int hue_dist(int a, int b);
            int d;
            d = (a > b) ? a - b : b - a;
            return (d <= 180) ? d : 360 - d;
        endfunction

        function int unsigned int_sqrt(longint unsigned v);
            int unsigned r;
            r = 0;
            for (int b = 15; b >= 0; b--) begin
                if (longint'(r | (1 << b)) * longint'(r | (1 << b)) <= v) r = r | (1 << b);
            end
            return r;
        endfunction

        function void add_sat(ref logic [31:0] bin, input int unsigned v);
            longint unsigned s;
            s = longint'(bin) + v;
            bin = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v < 3) return 3;
            return (v > hi) ? hi : v;
        endfunction

        function void load_pixel(logic [7:0] hue, logic [7:0] inten);
            int unsigned w, h, c, r;
            logic [8:0] hs;
            int gx, gy, hx, hy;
            c = col;
            r = row;
            w = clamp(cfg_width, MAXW);
            h = clamp(cfg_height, 1024);
            hs = 9'((int'(hue) * 360) / 255);
            for (int k = 0; k < 3; k++) begin
                win_i[k][0] = win_i[k][1];
                win_i[k][1] = win_i[k][2];
                win_h[k][0] = win_h[k][1];
                win_h[k][1] = win_h[k][2];
            end
            win_i[0][2] = line_i[MAXW + c];
            win_i[1][2] = line_i[c];
            win_i[2][2] = inten;
            win_h[0][2] = line_h[MAXW + c];
            win_h[1][2] = line_h[c];
            win_h[2][2] = hs;
            // interior pixel: Sobel on intensity, circular differences on hue
            if (r >= 2 && c >= 2) begin
                gx = (int'(win_i[2][2]) + 2 * win_i[2][1] + win_i[2][0])
                   - (int'(win_i[0][2]) + 2 * win_i[0][1] + win_i[0][0]);
                gy = (int'(win_i[2][2]) + 2 * win_i[1][2] + win_i[0][2])
                   - (int'(win_i[2][0]) + 2 * win_i[1][0] + win_i[0][0]);
                hx = hue_dist(win_h[2][2], win_h[0][2]) + 2 * hue_dist(win_h[2][1], win_h[0][1])
                   + hue_dist(win_h[2][0], win_h[0][0]);
                hy = hue_dist(win_h[2][2], win_h[2][0]) + 2 * hue_dist(win_h[1][2], win_h[1][0])
                   + hue_dist(win_h[0][2], win_h[0][0]);
                add_sat(grad_bins[win_i[1][1]], int_sqrt(gx * gx + gy * gy));
                add_sat(hue_bins[win_i[1][1]], int_sqrt(hx * hx + hy * hy));
            end
            line_i[MAXW + c] = line_i[c];
            line_i[c] = inten;
            line_h[MAXW + c] = line_h[c];
            line_h[c] = hs;
            if (c + 1 >= w) begin
                col = 0;
                row = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col = c + 1;
            end
        endfunction

        function void build_table();
            longint unsigned ci [BINS];
            longint unsigned ch [BINS];
            longint unsigned si, sh, vi, vh, v;
            int unsigned b;
            si = 0;
            sh = 0;
            b = (cfg_blend > 256) ? 256 : cfg_blend;
            for (int k = 0; k < BINS; k++) begin
                si += grad_bins[k];
                sh += hue_bins[k];
                ci[k] = si;
                ch[k] = sh;
            end
            eq_table[0] = '0;
            for (int k = 1; k < BINS; k++) begin
                vi = (ci[BINS-1] != 0) ? (255 * ci[k]) / ci[BINS-1] : 0;
                vh = (ch[BINS-1] != 0) ? (255 * ch[k]) / ch[BINS-1] : 0;
                v = (b * vi + (256 - b) * vh + 128) >> 8;
                eq_table[k] = (v > 255) ? 8'd255 : v[7:0];
            end
            foreach (grad_bins[k]) begin
                grad_bins[k] = '0;
                hue_bins[k] = '0;
            end
            col = 0;
            row = 0;
        endfunction

        // accepted input request
        function void note_request(t_in_item it);
            t_out_item res;
            case (it.operation)
                OP_LOAD: load_pixel(it.hue, it.intensity);
                OP_BUILD: begin
                    build_table();
                    res.kind = KIND_BUILD;
                    res.mapped_intensity = '0;
                    expected_results.push_back(res);
                end
                OP_MAP: begin
                    res.kind = KIND_MAP;
                    res.mapped_intensity = eq_table[it.intensity];
                    expected_results.push_back(res);
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        // accepted result
        task check_result(t_out_item got);
            t_out_item exp_res;
            results_seen++;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result kind=%0d value=%0d",
                                 got.kind, got.mapped_intensity));
            end else begin
                exp_res = expected_results.pop_front();
                if (got.kind !== exp_res.kind)
                    report($sformatf("kind %0d, want %0d", got.kind, exp_res.kind));
                if (got.mapped_intensity !== exp_res.mapped_intensity)
                    report($sformatf("mapped_intensity %0d, want %0d",
                                     got.mapped_intensity, exp_res.mapped_intensity));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    in_data = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_WIDTH;
    logic [10:0] cfg_data = '0;

    equalizer_scoreboard sb = new();
    bit gaps_on = 1'b1;
    int hold_cycles = 0;
    int requests_sent = 0;
    int builds_sent = 0;

    gradient_weighted_histogram_equalizer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) sb.check_result(o_out_data);
    end

    // receiver: long hold when asked, else random stall bursts
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                out_ready = 1'b0;
                hold_cycles--;
            end else if (burst > 0) begin
                out_ready = 1'b0;
                burst--;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                out_ready = 1'b0;
                burst = $urandom_range(0, 8);
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    // one request, with an optional idle burst ahead of it
    task automatic send_request(logic [1:0] op, logic [7:0] hue, logic [7:0] inten);
        t_in_item it;
        it.operation = op;
        it.hue = hue;
        it.intensity = inten;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data = it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(it);
        if (op != OP_UNUSED) requests_sent++;
        if (op == OP_BUILD) builds_sent++;
        @(negedge i_clk);
    endtask

    // stop offering, wait for every result, then let trailing loads finish
    task automatic drain();
        in_valid = 1'b0;
        while (sb.expected_results.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [10:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        sb.write_reg(idx, val);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one image with loads, some noise and maps, a build and a few maps
    task automatic run_image(int w, int h, int loads, int maps);
        for (int k = 0; k < loads; k++) begin
            if ($urandom_range(0, 30) == 0) send_request(OP_UNUSED, pick_byte(), pick_byte());
            if ($urandom_range(0, 25) == 0) send_request(OP_MAP, pick_byte(), pick_byte());
            send_request(OP_LOAD, pick_byte(), 8'($urandom_range(0, 255)));
        end
        send_request(OP_BUILD, pick_byte(), pick_byte());
        for (int k = 0; k < maps; k++) send_request(OP_MAP, pick_byte(), pick_byte());
    endtask

    // timeout
    initial begin
        #20ms;
        $display("gradient_weighted_histogram_equalizer_tb: done, errors");
        $finish;
    end

    initial begin
        int w, h, n;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset table, empty build, unused op, 3x3 image at extremes
        send_request(OP_MAP, 8'd0, 8'd255);
        send_request(OP_BUILD, 8'd0, 8'd0);
        send_request(OP_UNUSED, 8'd255, 8'd255);
        send_request(OP_MAP, 8'd255, 8'd7);
        drain();
        write_cfg(REG_WIDTH, 11'd3);
        write_cfg(REG_HEIGHT, 11'd3);
        write_cfg(REG_BLEND, 11'd0);
        send_request(OP_LOAD, 8'd0, 8'd0);
        send_request(OP_LOAD, 8'd255, 8'd255);
        send_request(OP_LOAD, 8'd128, 8'd0);
        send_request(OP_LOAD, 8'd255, 8'd255);
        send_request(OP_LOAD, 8'd0, 8'd128);
        send_request(OP_LOAD, 8'd127, 8'd0);
        send_request(OP_LOAD, 8'd0, 8'd255);
        send_request(OP_LOAD, 8'd255, 8'd0);
        send_request(OP_LOAD, 8'd64, 8'd255);
        send_request(OP_BUILD, 8'd0, 8'd0);
        send_request(OP_MAP, 8'd0, 8'd0);
        send_request(OP_MAP, 8'd0, 8'd128);
        send_request(OP_MAP, 8'd0, 8'd255);

        // receiver holds off while maps keep coming, so the queue backs up
        hold_cycles = 600;
        for (int k = 0; k < 12; k++) send_request(OP_MAP, 8'd0, 8'($urandom_range(0, 255)));
        drain();

        // random images across sizes and blend weights
        while (requests_sent < 1050) begin
            if (requests_sent > 850) gaps_on = 1'b0;
            case ($urandom_range(0, 9))
                0: begin w = 0; h = 2047; end
                1: begin w = 2047; h = 0; end
                2: begin w = 1024; h = 1024; end
                default: begin w = $urandom_range(3, 10); h = $urandom_range(3, 8); end
            endcase
            write_cfg(REG_WIDTH, 11'(w));
            write_cfg(REG_HEIGHT, 11'(h));
            case ($urandom_range(0, 5))
                0: write_cfg(REG_BLEND, 11'd0);
                1: write_cfg(REG_BLEND, 11'd256);
                2: write_cfg(REG_BLEND, 11'd511);
                default: write_cfg(REG_BLEND, 11'($urandom_range(0, 256)));
            endcase
            if (w > 10 || w < 3) n = $urandom_range(20, 40);
            else n = w * h + $urandom_range(0, 2) * $urandom_range(0, w * 2);
            run_image(w, h, n, $urandom_range(8, 20));
            drain();
        end

        $display("covered %0d requests, %0d builds, %0d results checked",
                 requests_sent, builds_sent, sb.results_seen);
        $display("image sizes from 3x3 to clamped 1024, blend weights 0 to saturated 511");
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("gradient_weighted_histogram_equalizer_tb: done, clean");
        end else begin
            $display("gradient_weighted_histogram_equalizer_tb: done, errors");
        end
        $finish;
    end
endmodule
